[rtl/sms_pkg.sv]
package sms_pkg;

   localparam int COEF_IN_BITS  = 16;
   localparam int COEF_OUT_BITS = 48;
   localparam int RAD_OUT_BITS  = 32;
   localparam int FIRST_BASE    = 2;
   localparam int FIRST_SQUARE  = 4;

   typedef struct packed {
      logic done;
      logic exact;
   } div_status_type;

endpackage

[rtl/surd_multiply_simplify.sv]
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  coefficient_a, radicand_a, coefficient_b, radicand_b
// rsp_      out        rsp_valid/rsp_stall  coefficient_out, radicand_out
//
// One word is simplified at a time; req_stall stays high until the result is in the
// output register. Each trial base takes one bound check and one pass through the
// shared restoring divider. Each square factor found adds a shift-add multiply.
// Up to about sqrt(radicand product) bases are tried. Reset is synchronous and
// active high. A result held by rsp_stall does not stop the next word from being
// taken.
module surd_multiply_simplify #(
   parameter int RADICAND_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [sms_pkg::COEF_IN_BITS-1:0]  req_coefficient_a,
   input  logic        [RADICAND_BITS-1:0]          req_radicand_a,
   input  logic signed [sms_pkg::COEF_IN_BITS-1:0]  req_coefficient_b,
   input  logic        [RADICAND_BITS-1:0]          req_radicand_b,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [sms_pkg::COEF_OUT_BITS-1:0] rsp_coefficient_out,
   output logic        [sms_pkg::RAD_OUT_BITS-1:0]  rsp_radicand_out
);
   import sms_pkg::*;

   localparam int RAD_BITS  = 2 * RADICAND_BITS;
   localparam int SQ_BITS   = RAD_BITS + 1;
   localparam int BASE_BITS = RADICAND_BITS + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type                         state_ff;
   logic [RAD_BITS-1:0]               rad_ff;
   logic [COEF_OUT_BITS-1:0]          coef_ff;
   logic [BASE_BITS-1:0]              base_ff;
   logic [SQ_BITS-1:0]                sq_ff;
   logic [SQ_BITS-1:0]                sq_in;
   logic [COEF_OUT_BITS-1:0]          acc_ff;
   logic [COEF_OUT_BITS-1:0]          mcand_ff;
   logic [BASE_BITS-1:0]              mplier_ff;
   logic                              div_start_ff;
   logic                              rsp_valid_ff;
   logic [COEF_OUT_BITS-1:0]          coef_out_ff;
   logic [RAD_OUT_BITS-1:0]           rad_out_ff;
   logic signed [2*COEF_IN_BITS-1:0]  coef_prod;
   logic [RAD_BITS-1:0]               rad_prod;
   logic [RAD_BITS-1:0]               div_quotient;
   div_status_type                    div_status;
   logic                              sq_fits;
   logic                              load_out;

   assign coef_prod = req_coefficient_a * req_coefficient_b;
   assign rad_prod  = RAD_BITS'(req_radicand_a) * RAD_BITS'(req_radicand_b);

   // (b+1)^2 = b^2 + 2b + 1
   assign sq_in = sq_ff + SQ_BITS'({base_ff, 1'b1});

   assign sq_fits  = (sq_ff <= SQ_BITS'(rad_ff));
   assign load_out = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   sms_divider #(
      .DIVIDEND_BITS (RAD_BITS),
      .DIVISOR_BITS  (SQ_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (rad_ff),
      .divisor  (sq_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_CHECK) && sq_fits;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  coef_ff  <= COEF_OUT_BITS'(coef_prod);
                  rad_ff   <= rad_prod;
                  base_ff  <= BASE_BITS'(FIRST_BASE);
                  sq_ff    <= SQ_BITS'(FIRST_SQUARE);
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (!sq_fits) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_status.done) begin
                  if (div_status.exact) begin
                     rad_ff    <= div_quotient;
                     acc_ff    <= '0;
                     mcand_ff  <= coef_ff;
                     mplier_ff <= base_ff;
                     state_ff  <= ST_MUL;
                  end else begin
                     base_ff  <= base_ff + BASE_BITS'(1);
                     sq_ff    <= sq_in;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_MUL: begin
               if (mplier_ff == '0) begin
                  coef_ff  <= acc_ff;
                  state_ff <= ST_CHECK;
               end else begin
                  if (mplier_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff  <= {mcand_ff[COEF_OUT_BITS-2:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[BASE_BITS-1:1]};
               end
            end
            ST_FINISH: begin
               if (load_out) begin
                  coef_out_ff <= coef_ff;
                  rad_out_ff  <= RAD_OUT_BITS'(rad_ff);
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coefficient_out = coef_out_ff;
   assign rsp_radicand_out    = rad_out_ff;

endmodule

[rtl/sms_divider.sv]
module sms_divider #(
   parameter int DIVIDEND_BITS = 32,
   parameter int DIVISOR_BITS  = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVIDEND_BITS-1:0]   dividend,
   input  logic [DIVISOR_BITS-1:0]    divisor,
   output logic [DIVIDEND_BITS-1:0]   quotient,
   output sms_pkg::div_status_type    status
);
   import sms_pkg::*;

   localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DIVISOR_BITS:0]    rem_shift;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;
   logic                     last_step;

   // One restoring step: bring down the next dividend bit and try the subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff      = rem_shift - {1'b0, divisor};
      fits      = ~diff[DIVISOR_BITS];
      rem_in    = fits ? diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
      quo_in    = {quo_ff[DIVIDEND_BITS-2:0], fits};
   end

   assign last_step = busy_ff && (cnt_ff == CNT_BITS'(DIVIDEND_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step && !start;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            cnt_ff  <= cnt_ff + CNT_BITS'(1);
            busy_ff <= !last_step;
         end
      end
   end

   assign quotient     = quo_ff;
   assign status.done  = done_ff;
   assign status.exact = (rem_ff == '0);

endmodule
